/* rtl/vwi_pkg.sv */
// Shared constants and types for the vertex welding indexer.
package vwi_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned VTX_W   = 3 * COORD_W;
  localparam int unsigned VIDX_W  = 10;

  // One stored vertex: x in the low word, z in the high word
  typedef logic [VTX_W-1:0] vtx_t;

  // Request from the scan controller to the vertex table
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    vtx_t              wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

/* rtl/vwi_table.sv */
// Vertex table: one write port, one read port with registered read data.
module vwi_table (
  input  logic              clk,
  input  vwi_pkg::mem_req_t req,
  output vwi_pkg::vtx_t     rd_data
);

  vwi_pkg::vtx_t mem [vwi_pkg::TABLE_DEPTH];
  vwi_pkg::vtx_t rd_data_r;

  // Write the new vertex; read the requested entry every cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/vwi_ctrl.sv */
// Scan controller: takes a vertex, walks the table, appends misses while there is room, drives the result word.
module vwi_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start,
  input  vwi_pkg::vtx_t                in_vtx,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vwi_pkg::VIDX_W-1:0]   out_index,
  output logic                         out_new,
  output logic                         out_ovf,
  output vwi_pkg::mem_req_t            mem_req,
  input  vwi_pkg::vtx_t                mem_rd_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam int unsigned AW = vwi_pkg::ADDR_W;
  localparam int unsigned CW = vwi_pkg::COUNT_W;
  localparam int unsigned XW = vwi_pkg::COORD_W;

  state_t                    state_r, state_nxt;
  vwi_pkg::vtx_t             vtx_r, vtx_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             ptr_r, ptr_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]             res_idx_r, res_idx_nxt;
  logic                      res_new_r, res_new_nxt;
  logic                      res_ovf_r, res_ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [vwi_pkg::VIDX_W-1:0] out_index_r, out_index_nxt;
  logic                      out_new_r, out_new_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic                      issue;
  logic                      hit;
  logic                      room;
  logic [AW+vwi_pkg::VIDX_W-1:0] idx_ext;

  // Equal as IEEE values: identical bits, or both zeros of either sign
  function automatic logic coord_eq(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic zz;
    zz = (a[XW-2:0] == '0) && (b[XW-2:0] == '0);
    return (a == b) || zz;
  endfunction

  assign issue = (ptr_r < count_r);
  assign room  = (count_r < CW'(vwi_pkg::TABLE_DEPTH));
  assign hit   = cmp_vld_r
               && coord_eq(mem_rd_data[XW-1:0],      vtx_r[XW-1:0])
               && coord_eq(mem_rd_data[2*XW-1:XW],   vtx_r[2*XW-1:XW])
               && coord_eq(mem_rd_data[3*XW-1:2*XW], vtx_r[3*XW-1:2*XW]);
  assign idx_ext = {{vwi_pkg::VIDX_W{1'b0}}, res_idx_r};

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    vtx_nxt       = vtx_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    res_idx_nxt   = res_idx_r;
    res_new_nxt   = res_new_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_new_nxt   = out_new_r;
    out_ovf_nxt   = out_ovf_r;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = count_r[AW-1:0];
    mem_req.wr_data = vtx_r;
    mem_req.rd_addr = ptr_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        // Take a vertex; a start word empties the table first
        if (in_valid) begin
          vtx_nxt   = in_vtx;
          ptr_nxt   = '0;
          state_nxt = ST_SCAN;
          if (in_start) begin
            count_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        // Compare the entry read last cycle, issue the next read
        if (hit) begin
          res_idx_nxt = cmp_idx_r;
          res_new_nxt = 1'b0;
          res_ovf_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else if (issue) begin
          ptr_nxt     = ptr_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = ptr_r[AW-1:0];
        end else begin
          // Miss: append if there is room, else flag overflow at index zero
          res_idx_nxt = room ? count_r[AW-1:0] : '0;
          res_new_nxt = room;
          res_ovf_nxt = !room;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand over the result once the output slot is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = idx_ext[vwi_pkg::VIDX_W-1:0];
          out_new_nxt   = res_new_r;
          out_ovf_nxt   = res_ovf_r;
          mem_req.wr_en = res_new_r;
          if (res_new_r) begin
            count_nxt = count_r + CW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    vtx_r       <= vtx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    res_idx_r   <= res_idx_nxt;
    res_new_r   <= res_new_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_index_r <= out_index_nxt;
    out_new_r   <= out_new_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_new   = out_new_r;
  assign out_ovf   = out_ovf_r;

endmodule

/* rtl/vertex_welding_indexer.sv */
// Vertex welding indexer: maps each incoming vertex to a deduplicated table index.
//
// Each input word carries one vertex (three IEEE single bit patterns). The block
// scans its vertex table from index 0 up, one entry per cycle through the
// table's single read port, and returns the index of the equal entry (+0 and -0
// count as equal). A vertex not in the table is appended at the next index and
// returned with is_new set; with the table full it returns index 0 and overflow.
// tuser bit 0 on the input empties the table before that vertex is handled.
// The scan covers every entry up to the matching one on a hit and every
// stored entry on a miss. The next input word is taken while the previous
// result still waits on the output. The table needs no clearing pass after
// reset.
module vertex_welding_indexer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // [31:0] coord_x, [63:32] coord_y, [95:64] coord_z
  input  logic         in_tuser,   // [0] start_req
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // [9:0] vertex_index, [15:10] zero
  output logic [1:0]   out_tuser   // [0] is_new, [1] overflow
);

  vwi_pkg::mem_req_t           mem_req;
  vwi_pkg::vtx_t               mem_rd_data;
  logic [vwi_pkg::VIDX_W-1:0]  out_index;

  vwi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_start    (in_tuser),
    .in_vtx      (in_tdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_index   (out_index),
    .out_new     (out_tuser[0]),
    .out_ovf     (out_tuser[1]),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  vwi_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // Pad the index to a whole-byte word
  assign out_tdata = {{(16 - vwi_pkg::VIDX_W){1'b0}}, out_index};

endmodule
